FILE: rtl/core/particle_pool_update_core_assert.svh
// Assertion macros for the particle pool core
`ifndef PARTICLE_POOL_UPDATE_CORE_ASSERT_SVH
`define PARTICLE_POOL_UPDATE_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define PPU_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define PPU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ppu_pkg.sv
// ----------------------------------------------------------------------------
// ppu_pkg
// Shared types and constants of the particle pool core.
// ----------------------------------------------------------------------------
package ppu_pkg;

    localparam int unsigned PoolSize  = 1024;
    localparam int unsigned SlotW     = $clog2(PoolSize);
    localparam int unsigned SpinRate  = 104;
    localparam int unsigned CmdDepth  = 4;
    localparam int unsigned CmdPtrW   = $clog2(CmdDepth);

    typedef enum logic [1:0] {
        OP_EMIT = 2'd0,
        OP_TICK = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CFG_SPREAD_X  = 3'd0,
        CFG_SPREAD_Y  = 3'd1,
        CFG_BASE_SIZE = 3'd2,
        CFG_SIZE_SPRD = 3'd3,
        CFG_LIFE_SPAN = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_READ
    } t_state;

    // Classified command passed from front to back
    typedef struct packed {
        t_op                op;
        logic [15:0]        delta_time;
        logic [31:0]        pos_x;
        logic [31:0]        pos_y;
        logic [31:0]        vel_x;
        logic [31:0]        vel_y;
        logic [SlotW-1:0]   slot;
        logic               slot_ok;
        logic [63:0]        random_bits;
    } t_cmd;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] life;
        logic [31:0] size;
        logic [15:0] angle;
        logic        active;
    } t_result;

    function automatic logic [31:0] sat32(input logic signed [33:0] x);
        if (x > 34'sh0_7FFF_FFFF)       return 32'h7FFF_FFFF;
        else if (x < -34'sh0_8000_0000) return 32'h8000_0000;
        else                            return x[31:0];
    endfunction

endpackage

FILE: rtl/core/ppu_front.sv
// ----------------------------------------------------------------------------
// ppu_front
// Accepts input items, drops unused codes and queues classified commands.
// ----------------------------------------------------------------------------
module ppu_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [1:0]           i_op,
    input  logic [15:0]          i_delta_time,
    input  logic [31:0]          i_emit_pos_x,
    input  logic [31:0]          i_emit_pos_y,
    input  logic [31:0]          i_emit_vel_x,
    input  logic [31:0]          i_emit_vel_y,
    input  logic [9:0]           i_read_slot,
    input  logic [63:0]          i_random_bits,
    output logic                 o_cmd_valid,
    output ppu_pkg::t_cmd        o_cmd,
    input  logic                 i_cmd_take
);
    import ppu_pkg::*;

    t_cmd               r_q [CmdDepth];
    logic [CmdPtrW-1:0] r_wr, r_rd;
    logic [CmdPtrW:0]   r_cnt;
    t_cmd               w_cmd;
    logic               w_acc, w_put;

    assign o_full = (r_cnt == (CmdPtrW+1)'(CmdDepth));
    assign w_acc  = i_push && !o_full;
    assign w_put  = w_acc && (i_op != OP_NONE);

    always_comb begin
        w_cmd             = '0;
        w_cmd.op          = t_op'(i_op);
        w_cmd.delta_time  = i_delta_time;
        w_cmd.pos_x       = i_emit_pos_x;
        w_cmd.pos_y       = i_emit_pos_y;
        w_cmd.vel_x       = i_emit_vel_x;
        w_cmd.vel_y       = i_emit_vel_y;
        w_cmd.slot        = SlotW'(i_read_slot);
        w_cmd.slot_ok     = ({22'd0, i_read_slot} < 32'(PoolSize));
        w_cmd.random_bits = i_random_bits;
    end

    always_ff @(posedge i_clk) begin
        if (w_put) begin
            r_q[r_wr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_put) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_cmd_take) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (CmdPtrW+1)'(w_put) - (CmdPtrW+1)'(i_cmd_take);
        end
    end

    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rd];

endmodule

FILE: rtl/core/ppu_back.sv
// ----------------------------------------------------------------------------
// ppu_back
// Carries out emit, tick and read on the particle memories.
// ----------------------------------------------------------------------------
module ppu_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    input  ppu_pkg::t_cmd        i_cmd,
    output logic                 o_cmd_take,
    input  logic [30:0]          i_spread_x,
    input  logic [30:0]          i_spread_y,
    input  logic [31:0]          i_base_size,
    input  logic [30:0]          i_size_spread,
    input  logic [30:0]          i_life_span,
    output logic                 o_res_valid,
    output ppu_pkg::t_result     o_res,
    input  logic                 i_res_pop,
    output logic                 o_busy
);
    import ppu_pkg::*;

    // Memories
    logic [31:0] r_m_life [PoolSize];
    logic [31:0] r_m_px   [PoolSize];
    logic [31:0] r_m_py   [PoolSize];
    logic [31:0] r_m_vx   [PoolSize];
    logic [31:0] r_m_vy   [PoolSize];
    logic [15:0] r_m_ang  [PoolSize];
    logic [31:0] r_m_size [PoolSize];
    logic [PoolSize-1:0] r_live;

    t_state           r_state, n_state;
    logic [SlotW-1:0] r_next_slot;
    logic [SlotW:0]   r_idx, n_idx;       // tick read address sweep
    logic [15:0]      r_delta;
    logic [15:0]      r_turn;

    // Read-data registers
    logic [31:0] r_rd_life, r_rd_px, r_rd_py, r_rd_vx, r_rd_vy, r_rd_size;
    logic [15:0] r_rd_ang;
    logic        r_rd_live;
    // Stage 1: products
    logic                r_s1_v;
    logic [SlotW-1:0]    r_s1_slot;
    logic                r_s1_live;
    logic [31:0]         r_s1_life, r_s1_px, r_s1_py;
    logic [15:0]         r_s1_ang;
    logic signed [48:0]  r_s1_mx, r_s1_my;
    logic                r_s0_v;
    logic [SlotW-1:0]    r_s0_slot;

    // Emit stage
    logic               r_e_v;
    logic [SlotW-1:0]   r_e_slot;
    logic [31:0]        r_e_px, r_e_py, r_e_vx, r_e_vy;
    logic [15:0]        r_e_ang;
    logic signed [47:0] r_e_mx, r_e_my, r_e_ms;

    logic        r_res_v, r_rd_pend, r_rd_ok;
    t_result     r_res;

    logic        w_emit, w_tick_rd, w_rd_req;
    logic [SlotW-1:0] w_addr;
    logic        w_wb;
    logic [31:0] w_life_n, w_px_n, w_py_n;
    logic [15:0] w_ang_n;
    logic        w_clear;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        o_cmd_take = 1'b0;
        w_emit     = 1'b0;
        w_tick_rd  = 1'b0;
        w_rd_req   = 1'b0;
        w_addr     = r_idx[SlotW-1:0];
        unique case (r_state)
            ST_IDLE: begin
                // Hold commands until the tick pipe and write stages have drained and any read result has been popped
                if (i_cmd_valid && !r_s0_v && !r_s1_v && !r_e_v && !r_rd_pend
                    && !r_res_v) begin
                    o_cmd_take = 1'b1;
                    unique case (i_cmd.op)
                        OP_EMIT: w_emit = 1'b1;
                        OP_TICK: begin
                            n_state = ST_TICK;
                            n_idx   = '0;
                        end
                        OP_READ: begin
                            w_rd_req = 1'b1;
                            w_addr   = i_cmd.slot;
                        end
                        default: ;
                    endcase
                end
            end
            ST_TICK: begin
                w_tick_rd = 1'b1;
                n_idx     = r_idx + 1'b1;
                if (r_idx == (SlotW+1)'(PoolSize - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Memory read port
    always_ff @(posedge i_clk) begin
        r_rd_life <= r_m_life[w_addr];
        r_rd_px   <= r_m_px[w_addr];
        r_rd_py   <= r_m_py[w_addr];
        r_rd_vx   <= r_m_vx[w_addr];
        r_rd_vy   <= r_m_vy[w_addr];
        r_rd_ang  <= r_m_ang[w_addr];
        r_rd_size <= r_m_size[w_addr];
        r_rd_live <= r_live[w_addr];
    end

    // Tick stage 1: velocity times delta
    always_ff @(posedge i_clk) begin
        r_s0_slot <= w_addr;
        r_s1_slot <= r_s0_slot;
        r_s1_live <= r_rd_live;
        r_s1_life <= r_rd_life;
        r_s1_px   <= r_rd_px;
        r_s1_py   <= r_rd_py;
        r_s1_ang  <= r_rd_ang;
        r_s1_mx   <= $signed(r_rd_vx) * $signed({1'b0, r_delta});
        r_s1_my   <= $signed(r_rd_vy) * $signed({1'b0, r_delta});
        if (o_cmd_take && i_cmd.op == OP_TICK) begin
            r_delta <= i_cmd.delta_time;
            r_turn  <= 16'((32'(i_cmd.delta_time) * 32'(SpinRate)) >> 16);
        end
    end

    // Tick stage 2: write back
    always_comb begin
        w_clear  = r_s1_live && ($signed(r_s1_life) <= 0);
        w_wb     = r_s1_v && r_s1_live && !w_clear;
        w_life_n = sat32(34'($signed(r_s1_life)) - 34'($signed({1'b0, r_delta})));
        w_px_n   = sat32(34'($signed(r_s1_px)) + 34'(r_s1_mx >>> 16));
        w_py_n   = sat32(34'($signed(r_s1_py)) + 34'(r_s1_my >>> 16));
        w_ang_n  = r_s1_ang + r_turn;
    end

    // Emit stage: spread products
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_e_slot <= r_next_slot;
            r_e_px   <= i_cmd.pos_x;
            r_e_py   <= i_cmd.pos_y;
            r_e_vx   <= i_cmd.vel_x;
            r_e_vy   <= i_cmd.vel_y;
            r_e_ang  <= i_cmd.random_bits[15:0];
            r_e_mx   <= $signed({1'b0, i_spread_x})
                      * $signed({1'b0, i_cmd.random_bits[31:16]} - 17'sd32768);
            r_e_my   <= $signed({1'b0, i_spread_y})
                      * $signed({1'b0, i_cmd.random_bits[47:32]} - 17'sd32768);
            r_e_ms   <= $signed({1'b0, i_size_spread})
                      * $signed({1'b0, i_cmd.random_bits[63:48]} - 17'sd32768);
        end
    end

    // Memory write port: emit and tick never overlap
    always_ff @(posedge i_clk) begin
        if (r_e_v) begin
            r_m_life[r_e_slot] <= {1'b0, i_life_span};
            r_m_px[r_e_slot]   <= r_e_px;
            r_m_py[r_e_slot]   <= r_e_py;
            r_m_ang[r_e_slot]  <= r_e_ang;
            r_m_vx[r_e_slot]   <= sat32(34'($signed(r_e_vx)) + 34'(r_e_mx >>> 16));
            r_m_vy[r_e_slot]   <= sat32(34'($signed(r_e_vy)) + 34'(r_e_my >>> 16));
            r_m_size[r_e_slot] <= sat32(34'($signed(i_base_size)) + 34'(r_e_ms >>> 16));
        end else if (w_wb) begin
            r_m_life[r_s1_slot] <= w_life_n;
            r_m_px[r_s1_slot]   <= w_px_n;
            r_m_py[r_s1_slot]   <= w_py_n;
            r_m_ang[r_s1_slot]  <= w_ang_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live      <= '0;
            r_next_slot <= SlotW'(PoolSize - 1);
            r_e_v       <= 1'b0;
            r_s0_v      <= 1'b0;
            r_s1_v      <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_res_v     <= 1'b0;
        end else begin
            r_e_v     <= w_emit;
            r_s0_v    <= w_tick_rd;
            r_s1_v    <= r_s0_v;
            r_rd_pend <= w_rd_req;
            if (w_emit) begin
                r_next_slot <= r_next_slot - 1'b1;  // wraps to the last slot
            end
            if (r_e_v) begin
                r_live[r_e_slot] <= 1'b1;
            end else if (r_s1_v && w_clear) begin
                r_live[r_s1_slot] <= 1'b0;
            end
            if (r_rd_pend) begin
                r_res_v <= 1'b1;
            end else if (i_res_pop) begin
                r_res_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_req) begin
            r_rd_ok <= i_cmd.slot_ok;
        end
        if (r_rd_pend) begin
            if (r_rd_ok && r_rd_live) begin
                r_res.active <= 1'b1;
                r_res.pos_x  <= r_rd_px;
                r_res.pos_y  <= r_rd_py;
                r_res.angle  <= r_rd_ang;
                r_res.life   <= r_rd_life;
                r_res.size   <= r_rd_size;
            end else begin
                r_res <= '0;
            end
        end
    end

    assign o_res_valid = r_res_v;
    assign o_res       = r_res;
    assign o_busy      = (r_state == ST_TICK);

endmodule

FILE: rtl/core/particle_pool_update_core.sv
// ----------------------------------------------------------------------------
// particle_pool_update_core
// Ring pool of 1024 particles with emit, Euler tick and slot read.
// ----------------------------------------------------------------------------
// An emit holds the back end until its registered emit stage has written the
// memories. A read passes the read-data registers, then the result register,
// before it reaches the outputs, and the back end then waits until the result
// is popped. A tick sweeps every slot through the single memory read port and
// holds the back end until the sweep and tick pipe drain. A four-entry command
// queue lets the input side keep accepting while a tick runs, until it fills.
module particle_pool_update_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_delta_time,
    input  logic [31:0] i_emit_pos_x,
    input  logic [31:0] i_emit_pos_y,
    input  logic [31:0] i_emit_vel_x,
    input  logic [31:0] i_emit_vel_y,
    input  logic [9:0]  i_read_slot,
    input  logic [63:0] i_random_bits,
    output logic        empty,
    input  logic        pop,
    output logic        o_slot_active,
    output logic [31:0] o_out_pos_x,
    output logic [31:0] o_out_pos_y,
    output logic [15:0] o_out_angle,
    output logic [31:0] o_out_life,
    output logic [31:0] o_out_size,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import ppu_pkg::*;

    `include "particle_pool_update_core_assert.svh"

    logic [30:0] r_spread_x, r_spread_y, r_size_spread, r_life_span;
    logic [31:0] r_base_size;
    logic        w_cmd_valid, w_cmd_take, w_res_valid, w_busy;
    t_cmd        w_cmd;
    t_result     w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spread_x    <= '0;
            r_spread_y    <= '0;
            r_base_size   <= 32'h0001_0000;
            r_size_spread <= '0;
            r_life_span   <= 31'h0001_0000;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SPREAD_X:  r_spread_x    <= i_cfg_data[30:0];
                CFG_SPREAD_Y:  r_spread_y    <= i_cfg_data[30:0];
                CFG_BASE_SIZE: r_base_size   <= i_cfg_data;
                CFG_SIZE_SPRD: r_size_spread <= i_cfg_data[30:0];
                CFG_LIFE_SPAN: r_life_span   <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    ppu_front u_front (
        .i_clk, .i_rst_n,
        .i_push       (push),
        .o_full       (full),
        .i_op, .i_delta_time, .i_emit_pos_x, .i_emit_pos_y,
        .i_emit_vel_x, .i_emit_vel_y, .i_read_slot, .i_random_bits,
        .o_cmd_valid  (w_cmd_valid),
        .o_cmd        (w_cmd),
        .i_cmd_take   (w_cmd_take)
    );

    ppu_back u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid  (w_cmd_valid),
        .i_cmd        (w_cmd),
        .o_cmd_take   (w_cmd_take),
        .i_spread_x   (r_spread_x),
        .i_spread_y   (r_spread_y),
        .i_base_size  (r_base_size),
        .i_size_spread(r_size_spread),
        .i_life_span  (r_life_span),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res),
        .i_res_pop    (pop),
        .o_busy       (w_busy)
    );

    assign empty         = !w_res_valid;
    assign o_slot_active = w_res.active;
    assign o_out_pos_x   = w_res.pos_x;
    assign o_out_pos_y   = w_res.pos_y;
    assign o_out_angle   = w_res.angle;
    assign o_out_life    = w_res.life;
    assign o_out_size    = w_res.size;

    `PPU_ASSERT_IMPL(a_take_needs_valid, w_cmd_take, w_cmd_valid, "command taken from empty queue")
    `PPU_ASSERT_IMPL(a_no_take_in_tick, w_busy, !w_cmd_take, "command taken during tick sweep")
    `PPU_ASSERT_NEXT(a_res_holds, (!empty && !pop), (!empty && $stable(o_out_life)), "result lost")
    `PPU_ASSERT_IMPL(a_inactive_zero, (!empty && !o_slot_active), (o_out_pos_x == 32'd0), "inactive result not zero")

endmodule
